// ===== design/dart_pkg.sv =====
// ----------------------------------------------------------------------------
// dart_pkg: shared constants for the dipole angle restraint torque core
// Field widths, stream packing widths, register indexes and pipeline depths.
// ----------------------------------------------------------------------------
package dart_pkg;

    localparam int NUM_TYPES_DEF = 2;

    localparam int COORD_W    = 32;
    localparam int LEN_W      = 31;
    localparam int COS_W      = 18;
    localparam int OUT_W      = 48;

    localparam int S_TDATA_W  = 320;
    localparam int M_TDATA_W  = 192;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STIFF_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_BASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;

    localparam logic [COS_W-1:0] COS_RESET = 18'd65536;

    localparam int SQRT_STEPS = 32;
    localparam int COS_QBITS  = 32;
    localparam int TRQ_QBITS  = 48;

endpackage

// ===== design/dipole_angle_restraint_torque_core.sv =====
// ----------------------------------------------------------------------------
// dipole_angle_restraint_torque_core
// Harmonic restraint on the cosine of the dipole orientation angle: wraps the
// displacement, takes its length, forms cosGamma and emits energy and torque.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the skid register is empty;
// the 32-step square root and the 32-bit and 48-bit restoring dividers
// are unrolled one step per pipeline stage. An output register plus a skid
// register decouple the result side. Reset (rst_n low, asynchronous) clears
// all valid bits and loads the registers with box 0, stiffness 0 and rest
// cosine 1.0.
module dipole_angle_restraint_torque_core #(
    parameter int NUM_TYPES = dart_pkg::NUM_TYPES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dart_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dart_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // ref_pos_x/y/z, dip_pos_x/y/z, moment_x/y/z, moment_length, pad
    input  logic [dart_pkg::S_TDATA_W-1:0]   s_tdata,
    // angle_type
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // torque_x, torque_y, torque_z, energy
    output logic [dart_pkg::M_TDATA_W-1:0]   m_tdata,
    // degenerate
    output logic                             m_tuser
);
    import dart_pkg::*;

    localparam int TIDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

    typedef struct packed {
        logic [TIDX_W-1:0]  ts;
        logic [2:0][32:0]   d;
        logic [2:0][31:0]   mu;
        logic [30:0]        ml;
    } sa_t;

    typedef struct packed {
        logic [TIDX_W-1:0]  ts;
        logic [2:0][31:0]   d;
        logic [2:0][31:0]   mu;
        logic [30:0]        ml;
    } sb_t;

    typedef struct packed {
        logic [TIDX_W-1:0]  ts;
        logic [2:0][63:0]   sq;
        logic [2:0][63:0]   dot;
        logic [2:0][63:0]   cra;
        logic [2:0][63:0]   crb;
        logic [30:0]        ml;
    } sc_t;

    typedef struct packed {
        logic [TIDX_W-1:0]  ts;
        logic [63:0]        sumsq;
        logic [63:0]        pos;
        logic [63:0]        negs;
        logic [2:0][63:0]   cm;
        logic [2:0]         cn;
        logic [30:0]        ml;
    } sd_t;

    typedef struct packed {
        logic [TIDX_W-1:0]  ts;
        logic               dneg;
        logic [63:0]        dm;
        logic [2:0][63:0]   cm;
        logic [2:0]         cn;
        logic [30:0]        ml;
    } sqc_t;

    typedef struct packed {
        logic [TIDX_W-1:0]  ts;
        logic               dneg;
        logic [62:0]        rmu;
        logic [2:0][63:0]   cm;
        logic [2:0]         cn;
    } cdc_t;

    typedef struct packed {
        logic [TIDX_W-1:0]  ts;
        logic               deg;
        logic [31:0]        dev;
        logic [62:0]        rmu;
        logic [2:0][63:0]   cm;
        logic [2:0]         cn;
    } sf_t;

    typedef struct packed {
        logic               deg;
        logic [31:0]        dev;
        logic [63:0]        kdg;
        logic [62:0]        rmu;
        logic [2:0][63:0]   cm;
        logic [2:0]         cn;
    } sg_t;

    typedef struct packed {
        logic               deg;
        logic               kneg;
        logic               eneg;
        logic [62:0]        kmag;
        logic [31:0]        devmag;
        logic [62:0]        rmu;
        logic [2:0][63:0]   cm;
        logic [2:0]         cn;
    } sh_t;

    typedef struct packed {
        logic                   deg;
        logic                   kneg;
        logic                   eneg;
        logic [63:0]            e0;
        logic [62:0]            e1;
        logic [2:0][3:0][63:0]  pp;
        logic [62:0]            rmu;
        logic [2:0]             cn;
    } sp_t;

    typedef struct packed {
        logic               deg;
        logic               kneg;
        logic               eneg;
        logic [63:0]        emag;
        logic [62:0]        rmu;
        logic [2:0]         cn;
    } tdc_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]         box_reg   [3];
    logic signed [31:0]       stiff_reg [NUM_TYPES];
    logic signed [COS_W-1:0]  cosr_reg  [NUM_TYPES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_reg[i] <= '0;
            end
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                stiff_reg[t] <= '0;
                cosr_reg[t]  <= COS_RESET;
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index >= REG_BOX_X && cfg_index <= REG_BOX_Z)
            begin
                box_reg[cfg_index[1:0]] <= cfg_data[LEN_W-1:0];
            end
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                if (cfg_index == REG_STIFF_BASE + CFG_IDX_W'(t))
                begin
                    stiff_reg[t] <= cfg_data;
                end
                if (cfg_index == REG_COS_BASE + CFG_IDX_W'(t))
                begin
                    cosr_reg[t] <= cfg_data[COS_W-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic en;
    logic skid_v_reg;
    logic out_v_reg;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    // Stage A: raw displacement, type select
    logic a_v_reg;
    sa_t  a_reg;
    sa_t  a_next;

    always_comb
    begin
        a_next.ts = (int'(s_tuser) < NUM_TYPES) ? TIDX_W'(s_tuser) : '0;
        for (int i = 0; i < 3; i++)
        begin
            a_next.d[i]  = 33'($signed(s_tdata[i*32 +: 32]))
                         - 33'($signed(s_tdata[96 + i*32 +: 32]));
            a_next.mu[i] = s_tdata[192 + i*32 +: 32];
        end
        a_next.ml = s_tdata[288 +: LEN_W];
    end

    // Stage B: minimum image wrap and saturation
    logic b_v_reg;
    sb_t  b_reg;
    sb_t  b_next;

    always_comb
    begin
        logic signed [35:0] dv;
        logic signed [35:0] two;
        logic signed [35:0] ll;
        logic signed [35:0] w;
        b_next.ts = a_reg.ts;
        b_next.mu = a_reg.mu;
        b_next.ml = a_reg.ml;
        for (int i = 0; i < 3; i++)
        begin
            dv  = 36'($signed(a_reg.d[i]));
            two = dv <<< 1;
            ll  = $signed({5'b0, box_reg[i]});
            if (box_reg[i] != '0 && dv > 0 && two > ll)
            begin
                w = dv - ll;
            end
            else if (box_reg[i] != '0 && dv < 0 && -two > ll)
            begin
                w = dv + ll;
            end
            else
            begin
                w = dv;
            end
            if (w > 36'sd2147483647)
            begin
                b_next.d[i] = 32'h7fff_ffff;
            end
            else if (w < -36'sd2147483648)
            begin
                b_next.d[i] = 32'h8000_0000;
            end
            else
            begin
                b_next.d[i] = w[31:0];
            end
        end
    end

    // Stage C: all 32x32 products
    logic c_v_reg;
    sc_t  c_reg;
    sc_t  c_next;

    always_comb
    begin
        c_next.ts = b_reg.ts;
        c_next.ml = b_reg.ml;
        for (int i = 0; i < 3; i++)
        begin
            c_next.sq[i]  = $signed(b_reg.d[i]) * $signed(b_reg.d[i]);
            c_next.dot[i] = $signed(b_reg.mu[i]) * $signed(b_reg.d[i]);
        end
        c_next.cra[0] = $signed(b_reg.d[1]) * $signed(b_reg.mu[2]);
        c_next.crb[0] = $signed(b_reg.d[2]) * $signed(b_reg.mu[1]);
        c_next.cra[1] = $signed(b_reg.d[2]) * $signed(b_reg.mu[0]);
        c_next.crb[1] = $signed(b_reg.d[0]) * $signed(b_reg.mu[2]);
        c_next.cra[2] = $signed(b_reg.d[0]) * $signed(b_reg.mu[1]);
        c_next.crb[2] = $signed(b_reg.d[1]) * $signed(b_reg.mu[0]);
    end

    // Stage D: sums and cross product magnitudes
    logic d_v_reg;
    sd_t  d_reg;
    sd_t  d_next;

    always_comb
    begin
        logic signed [64:0] diff;
        d_next.ts    = c_reg.ts;
        d_next.ml    = c_reg.ml;
        d_next.sumsq = c_reg.sq[0] + c_reg.sq[1] + c_reg.sq[2];
        d_next.pos   = '0;
        d_next.negs  = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (c_reg.dot[i][63])
            begin
                d_next.negs = d_next.negs - c_reg.dot[i];
            end
            else
            begin
                d_next.pos = d_next.pos + c_reg.dot[i];
            end
            diff = 65'($signed(c_reg.cra[i])) - 65'($signed(c_reg.crb[i]));
            d_next.cn[i] = diff[64];
            d_next.cm[i] = diff[64] ? 64'(-diff) : diff[63:0];
        end
    end

    // Stage E: signed dot magnitude; feeds the square root chain
    logic        sq_v_reg   [SQRT_STEPS+1];
    logic [63:0] sq_x_reg   [SQRT_STEPS+1];
    logic [63:0] sq_res_reg [SQRT_STEPS+1];
    sqc_t        sq_c_reg   [SQRT_STEPS+1];
    sqc_t        e_next;

    always_comb
    begin
        e_next.ts   = d_reg.ts;
        e_next.cm   = d_reg.cm;
        e_next.cn   = d_reg.cn;
        e_next.ml   = d_reg.ml;
        e_next.dneg = d_reg.negs > d_reg.pos;
        e_next.dm   = e_next.dneg ? d_reg.negs - d_reg.pos : d_reg.pos - d_reg.negs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg     <= 1'b0;
            b_v_reg     <= 1'b0;
            c_v_reg     <= 1'b0;
            d_v_reg     <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg     <= s_tvalid;
            b_v_reg     <= a_v_reg;
            c_v_reg     <= b_v_reg;
            d_v_reg     <= c_v_reg;
            sq_v_reg[0] <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            d_reg         <= d_next;
            sq_x_reg[0]   <= d_reg.sumsq;
            sq_res_reg[0] <= '0;
            sq_c_reg[0]   <= e_next;
        end
    end

    // Square root, one result bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2*j);
        logic [63:0] rb;
        assign rb = sq_res_reg[j] + SQ_BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[j+1] <= sq_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_c_reg[j+1] <= sq_c_reg[j];
                if (sq_x_reg[j] >= rb)
                begin
                    sq_x_reg[j+1]   <= sq_x_reg[j] - rb;
                    sq_res_reg[j+1] <= (sq_res_reg[j] >> 1) + SQ_BIT;
                end
                else
                begin
                    sq_x_reg[j+1]   <= sq_x_reg[j];
                    sq_res_reg[j+1] <= sq_res_reg[j] >> 1;
                end
            end
        end
    end

    // rmu = r * moment_length; feeds the cosine divider
    logic        cd_v_reg   [COS_QBITS+1];
    logic [63:0] cd_rem_reg [COS_QBITS+1];
    logic [31:0] cd_nb_reg  [COS_QBITS+1];
    logic [31:0] cd_q_reg   [COS_QBITS+1];
    logic        cd_ovf_reg [COS_QBITS+1];
    cdc_t        cd_c_reg   [COS_QBITS+1];
    cdc_t        rm_next;
    sqc_t        sq_last;

    always_comb
    begin
        sq_last      = sq_c_reg[SQRT_STEPS];
        rm_next.ts   = sq_last.ts;
        rm_next.dneg = sq_last.dneg;
        rm_next.cm   = sq_last.cm;
        rm_next.cn   = sq_last.cn;
        rm_next.rmu  = sq_res_reg[SQRT_STEPS][31:0] * sq_last.ml;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            cd_v_reg[0] <= sq_v_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_c_reg[0]   <= rm_next;
            cd_rem_reg[0] <= {16'b0, sq_last.dm[63:16]};
            cd_nb_reg[0]  <= {sq_last.dm[15:0], 16'b0};
            cd_q_reg[0]   <= '0;
            cd_ovf_reg[0] <= 1'b0;
        end
    end

    // cosGamma divider: restoring, one quotient bit per stage
    for (genvar j = 0; j < COS_QBITS; j++) begin : g_cdiv
        logic [63:0] t;
        logic [63:0] dvs;
        logic        ge;
        assign dvs = {1'b0, cd_c_reg[j].rmu};
        assign t   = {cd_rem_reg[j][62:0], cd_nb_reg[j][31]};
        assign ge  = t >= dvs;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                cd_v_reg[j+1] <= cd_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cd_c_reg[j+1]   <= cd_c_reg[j];
                cd_rem_reg[j+1] <= ge ? t - dvs : t;
                cd_nb_reg[j+1]  <= cd_nb_reg[j] << 1;
                cd_q_reg[j+1]   <= {cd_q_reg[j][30:0], ge};
                // quotient too large for 32 bits: decided by the first step
                cd_ovf_reg[j+1] <= (j == 0) ? (cd_rem_reg[j] >= dvs) : cd_ovf_reg[j];
            end
        end
    end

    // Stage F: clamp cosGamma, subtract rest cosine
    logic f_v_reg;
    sf_t  f_reg;
    sf_t  f_next;

    always_comb
    begin
        cdc_t               cl;
        logic [31:0]        cmag;
        logic signed [32:0] cosg;
        logic signed [33:0] dv;
        cl   = cd_c_reg[COS_QBITS];
        cmag = (cd_ovf_reg[COS_QBITS] || cd_q_reg[COS_QBITS] > 32'h8000_0000)
             ? 32'h8000_0000 : cd_q_reg[COS_QBITS];
        cosg = cl.dneg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
        dv   = 34'(cosg) - 34'(cosr_reg[cl.ts]);
        f_next.ts  = cl.ts;
        f_next.deg = cl.rmu == '0;
        f_next.rmu = cl.rmu;
        f_next.cm  = cl.cm;
        f_next.cn  = cl.cn;
        if (dv > 34'sd2147483647)
        begin
            f_next.dev = 32'h7fff_ffff;
        end
        else if (dv < -34'sd2147483648)
        begin
            f_next.dev = 32'h8000_0000;
        end
        else
        begin
            f_next.dev = dv[31:0];
        end
    end

    // Stage G: k * dev
    logic g_v_reg;
    sg_t  g_reg;
    sg_t  g_next;

    always_comb
    begin
        g_next.deg = f_reg.deg;
        g_next.dev = f_reg.dev;
        g_next.rmu = f_reg.rmu;
        g_next.cm  = f_reg.cm;
        g_next.cn  = f_reg.cn;
        g_next.kdg = stiff_reg[f_reg.ts] * $signed(f_reg.dev);
    end

    // Stage H: magnitudes and signs
    logic h_v_reg;
    sh_t  h_reg;
    sh_t  h_next;

    always_comb
    begin
        h_next.deg    = g_reg.deg;
        h_next.rmu    = g_reg.rmu;
        h_next.cm     = g_reg.cm;
        h_next.cn     = g_reg.cn;
        h_next.kneg   = g_reg.kdg[63];
        h_next.eneg   = g_reg.kdg[63] != g_reg.dev[31];
        h_next.kmag   = g_reg.kdg[63] ? 63'(-g_reg.kdg) : g_reg.kdg[62:0];
        h_next.devmag = g_reg.dev[31] ? 32'(-g_reg.dev) : g_reg.dev;
    end

    // Stage P: 32x32 partial products
    logic p_v_reg;
    sp_t  p_reg;
    sp_t  p_next;

    always_comb
    begin
        logic [63:0] a2;
        a2 = {h_reg.kmag, 1'b0};
        p_next.deg  = h_reg.deg;
        p_next.kneg = h_reg.kneg;
        p_next.eneg = h_reg.eneg;
        p_next.rmu  = h_reg.rmu;
        p_next.cn   = h_reg.cn;
        p_next.e0   = h_reg.kmag[31:0] * h_reg.devmag;
        p_next.e1   = h_reg.kmag[62:32] * h_reg.devmag;
        for (int i = 0; i < 3; i++)
        begin
            p_next.pp[i][0] = a2[31:0]  * h_reg.cm[i][31:0];
            p_next.pp[i][1] = a2[31:0]  * h_reg.cm[i][63:32];
            p_next.pp[i][2] = a2[63:32] * h_reg.cm[i][31:0];
            p_next.pp[i][3] = a2[63:32] * h_reg.cm[i][63:32];
        end
    end

    // Stage S: sum partial products; feeds the torque dividers
    logic             td_v_reg   [TRQ_QBITS+1];
    logic [2:0][79:0] td_rem_reg [TRQ_QBITS+1];
    logic [2:0][47:0] td_nb_reg  [TRQ_QBITS+1];
    logic [2:0][47:0] td_q_reg   [TRQ_QBITS+1];
    logic [2:0]       td_ovf_reg [TRQ_QBITS+1];
    tdc_t             td_c_reg   [TRQ_QBITS+1];
    tdc_t             s_next;
    logic [2:0][127:0] s_prod;

    always_comb
    begin
        logic [95:0] ep;
        ep = {32'b0, p_reg.e0} + {1'b0, p_reg.e1, 32'b0};
        s_next.deg  = p_reg.deg;
        s_next.kneg = p_reg.kneg;
        s_next.eneg = p_reg.eneg;
        s_next.rmu  = p_reg.rmu;
        s_next.cn   = p_reg.cn;
        s_next.emag = ep[95:32];
        for (int i = 0; i < 3; i++)
        begin
            s_prod[i] = {64'b0, p_reg.pp[i][0]}
                      + {32'b0, p_reg.pp[i][1], 32'b0}
                      + {32'b0, p_reg.pp[i][2], 32'b0}
                      + {p_reg.pp[i][3], 64'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg     <= 1'b0;
            g_v_reg     <= 1'b0;
            h_v_reg     <= 1'b0;
            p_v_reg     <= 1'b0;
            td_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg     <= cd_v_reg[COS_QBITS];
            g_v_reg     <= f_v_reg;
            h_v_reg     <= g_v_reg;
            p_v_reg     <= h_v_reg;
            td_v_reg[0] <= p_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg       <= f_next;
            g_reg       <= g_next;
            h_reg       <= h_next;
            p_reg       <= p_next;
            td_c_reg[0] <= s_next;
            td_q_reg[0] <= '0;
            td_ovf_reg[0] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                td_rem_reg[0][i] <= s_prod[i][127:48];
                td_nb_reg[0][i]  <= s_prod[i][47:0];
            end
        end
    end

    // Torque dividers: divide by rmu * 2^16, one quotient bit per stage
    for (genvar j = 0; j < TRQ_QBITS; j++) begin : g_tdiv
        logic [79:0]      dvs;
        logic [2:0][79:0] t;
        logic [2:0]       ge;
        assign dvs = {1'b0, td_c_reg[j].rmu, 16'b0};

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                t[i]  = {td_rem_reg[j][i][78:0], td_nb_reg[j][i][47]};
                ge[i] = t[i] >= dvs;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                td_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                td_v_reg[j+1] <= td_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                td_c_reg[j+1] <= td_c_reg[j];
                for (int i = 0; i < 3; i++)
                begin
                    td_rem_reg[j+1][i] <= ge[i] ? t[i] - dvs : t[i];
                    td_nb_reg[j+1][i]  <= td_nb_reg[j][i] << 1;
                    td_q_reg[j+1][i]   <= {td_q_reg[j][i][46:0], ge[i]};
                    td_ovf_reg[j+1][i] <= (j == 0) ? (td_rem_reg[j][i] >= dvs)
                                                   : td_ovf_reg[j][i];
                end
            end
        end
    end

    // Final saturation and sign
    logic [M_TDATA_W-1:0] fin_data;
    logic                 fin_deg;

    always_comb
    begin
        tdc_t        tl;
        logic        ng;
        logic [47:0] lim;
        logic [47:0] mg;
        tl      = td_c_reg[TRQ_QBITS];
        fin_deg = tl.deg;
        for (int i = 0; i < 3; i++)
        begin
            ng  = tl.kneg != tl.cn[i];
            lim = ng ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
            mg  = (td_ovf_reg[TRQ_QBITS][i] || td_q_reg[TRQ_QBITS][i] > lim)
                ? lim : td_q_reg[TRQ_QBITS][i];
            fin_data[i*OUT_W +: OUT_W] = tl.deg ? '0 : (ng ? -mg : mg);
        end
        lim = tl.eneg ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
        mg  = (tl.emag > {16'b0, lim}) ? lim : tl.emag[47:0];
        fin_data[3*OUT_W +: OUT_W] = tl.deg ? '0 : (tl.eneg ? -mg : mg);
    end

    // Output register and skid register
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_user_reg;
    logic [M_TDATA_W-1:0] skid_data_reg;
    logic                 skid_user_reg;
    logic                 out_free;

    assign out_free = !out_v_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_tready)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (td_v_reg[TRQ_QBITS])
        begin
            out_v_reg  <= 1'b1;
            skid_v_reg <= !out_free;
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (m_tready)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end
        else if (td_v_reg[TRQ_QBITS])
        begin
            if (out_free)
            begin
                out_data_reg <= fin_data;
                out_user_reg <= fin_deg;
            end
            else
            begin
                skid_data_reg <= fin_data;
                skid_user_reg <= fin_deg;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid holds a result while output register is empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && !m_tready) |=> skid_v_reg)
        else $error("skid result dropped without a take");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate result carries nonzero data");

    a_zero_divisor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (cd_v_reg[1] && cd_c_reg[1].rmu == '0) |-> cd_ovf_reg[1])
        else $error("zero divisor not flagged as overflow");
`endif

endmodule
